/* rtl/prast_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Parabola rasterizer package
// Opcodes, the screen width register layout and the flag groups shared by the
// step logic and the top level.
// -----------------------------------------------------------------------------
package prast_pkg;

	// Kind of an input item, carried on tuser.
	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	// Screen width register.
	localparam int unsigned SW_BITS = 13;
	localparam logic [SW_BITS-1:0] SW_RESET = 13'd640;

	// Per-curve flags kept in the state registers.
	typedef struct packed {
		logic active;
		logic opens_right;
	} state_flags_t;

	// Flags of one result item.
	typedef struct packed {
		logic point_valid;
		logic last;
	} res_flags_t;

endpackage
`default_nettype wire

/* rtl/parabola_rasterizer.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Parabola rasterizer
// Streams the point pairs of y^2 = 2|p|x, one pair per advance item.
// -----------------------------------------------------------------------------
// A start item (tuser 0) loads the vertex and p and answers with an all-zero
// item; each advance item (tuser 1) answers with the current column and the
// two mirrored rows, then steps toward the neighbor with the smallest
// residual. The block takes one item per clock while the output register
// is free; each item passes the input register, then the step logic ahead
// of the output register. The step logic reads and rewrites the curve state
// for each item. The screen width may only be written while no item is in
// flight.
module parabola_rasterizer #(
	parameter int COORD_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,

	// Screen width register write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [prast_pkg::SW_BITS-1:0]        cfg_data,

	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata, lowest bit first: vertex_x, vertex_y, focal_param, zero fill.
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
	// tuser: opcode.
	input  logic                                 s_axis_tuser,

	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata, lowest bit first: point_x, point_y_upper, point_y_lower, zero fill.
	output logic [((3*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
	// tuser: point_valid.
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);
	import prast_pkg::*;

	localparam int CW     = COORD_BITS + 2;
	localparam int RW     = 2 * COORD_BITS + 4;
	localparam int OUT_DW = ((3 * CW + 7) / 8) * 8;

	// Input register.
	logic                         valid_s1;
	opcode_t                      op_s1;
	logic signed [COORD_BITS-1:0] vx_s1, vy_s1, vp_s1;

	// Output register.
	logic                         valid_s2;
	logic signed [CW-1:0]         px_s2, pyu_s2, pyl_s2;
	res_flags_t                   flags_s2;

	// Curve state.
	logic [SW_BITS-1:0]           sw_q;
	state_flags_t                 flags_q, nxt_flags;
	logic signed [COORD_BITS-1:0] orgx_q, orgy_q, nxt_orgx, nxt_orgy;
	logic [COORD_BITS-2:0]        pmag_q, nxt_pmag;
	logic [COORD_BITS-1:0]        ox_q, nxt_ox;
	logic [COORD_BITS:0]          oy_q, nxt_oy;
	logic signed [RW-1:0]         resid_q, nxt_resid;
	logic signed [CW-1:0]         res_x, res_yu, res_yl;
	res_flags_t                   res_flags;

	logic out_free, fire_s1, fire_in;

	// The output register frees up when it is empty or being drained, so an
	// item moves on every cycle while the downstream side keeps up.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign fire_in       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) begin
			op_s1 <= opcode_t'(s_axis_tuser);
			vx_s1 <= s_axis_tdata[COORD_BITS-1:0];
			vy_s1 <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
			vp_s1 <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
		end
	end

	prast_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.op            (op_s1),
		.vertex_x      (vx_s1),
		.vertex_y      (vy_s1),
		.focal_param   (vp_s1),
		.visible_cols  (sw_q),
		.flags         (flags_q),
		.origin_x      (orgx_q),
		.origin_y      (orgy_q),
		.param_mag     (pmag_q),
		.offset_x      (ox_q),
		.offset_y      (oy_q),
		.resid         (resid_q),
		.nxt_flags     (nxt_flags),
		.nxt_origin_x  (nxt_orgx),
		.nxt_origin_y  (nxt_orgy),
		.nxt_param_mag (nxt_pmag),
		.nxt_offset_x  (nxt_ox),
		.nxt_offset_y  (nxt_oy),
		.nxt_resid     (nxt_resid),
		.point_x       (res_x),
		.point_y_upper (res_yu),
		.point_y_lower (res_yl),
		.res_flags     (res_flags)
	);

	// Curve state and the screen width register. The residual tracks
	// y^2 - 2|p|x at the current offsets and starts at zero on the vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q    <= SW_RESET;
			flags_q <= '0;
			orgx_q  <= '0;
			orgy_q  <= '0;
			pmag_q  <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			resid_q <= '0;
		end else begin
			if (cfg_valid) begin
				sw_q <= cfg_data;
			end
			if (fire_s1) begin
				flags_q <= nxt_flags;
				orgx_q  <= nxt_orgx;
				orgy_q  <= nxt_orgy;
				pmag_q  <= nxt_pmag;
				ox_q    <= nxt_ox;
				oy_q    <= nxt_oy;
				resid_q <= nxt_resid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			px_s2    <= res_x;
			pyu_s2   <= res_yu;
			pyl_s2   <= res_yl;
			flags_s2 <= res_flags;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_DW'({pyl_s2, pyu_s2, px_s2});
	assign m_axis_tuser  = flags_s2.point_valid;
	assign m_axis_tlast  = flags_s2.last;

`ifndef SYNTH
	// A start item leaves a loaded curve sitting on its vertex.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (op_s1 == OP_START) |=>
			flags_q.active && (ox_q == '0) && (oy_q == '0) && (resid_q == '0))
		else $error("start item did not load the curve");

	// Ending a curve unloads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_flags.last |=> !flags_q.active)
		else $error("curve still loaded after its last item");

	// The offsets only move when an item passes through the step logic.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(ox_q) && $stable(oy_q) && $stable(resid_q))
		else $error("curve state changed with no item");

	// An advance moves each offset by at most one.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (op_s1 == OP_ADVANCE) |=>
			((ox_q == $past(ox_q)) || (ox_q == $past(ox_q) + 1'b1)) &&
			((oy_q == $past(oy_q)) || (oy_q == $past(oy_q) + 1'b1)))
		else $error("offset jumped by more than one");
`endif

endmodule
`default_nettype wire

/* rtl/prast_step.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Parabola rasterizer step logic
// Computes the result item and the next curve state for one input item. The
// residual y^2 - 2px is carried incrementally, so no multiplier is needed.
// -----------------------------------------------------------------------------
module prast_step #(
	parameter int COORD_BITS = 13
) (
	input  prast_pkg::opcode_t                      op,
	input  logic signed [COORD_BITS-1:0]            vertex_x,
	input  logic signed [COORD_BITS-1:0]            vertex_y,
	input  logic signed [COORD_BITS-1:0]            focal_param,
	input  logic [prast_pkg::SW_BITS-1:0]           visible_cols,
	input  prast_pkg::state_flags_t                 flags,
	input  logic signed [COORD_BITS-1:0]            origin_x,
	input  logic signed [COORD_BITS-1:0]            origin_y,
	input  logic [COORD_BITS-2:0]                   param_mag,
	input  logic [COORD_BITS-1:0]                   offset_x,
	input  logic [COORD_BITS:0]                     offset_y,
	input  logic signed [2*COORD_BITS+3:0]          resid,
	output prast_pkg::state_flags_t                 nxt_flags,
	output logic signed [COORD_BITS-1:0]            nxt_origin_x,
	output logic signed [COORD_BITS-1:0]            nxt_origin_y,
	output logic [COORD_BITS-2:0]                   nxt_param_mag,
	output logic [COORD_BITS-1:0]                   nxt_offset_x,
	output logic [COORD_BITS:0]                     nxt_offset_y,
	output logic signed [2*COORD_BITS+3:0]          nxt_resid,
	output logic signed [COORD_BITS+1:0]            point_x,
	output logic signed [COORD_BITS+1:0]            point_y_upper,
	output logic signed [COORD_BITS+1:0]            point_y_lower,
	output prast_pkg::res_flags_t                   res_flags
);
	import prast_pkg::*;

	localparam int CW   = COORD_BITS + 2;
	localparam int RW   = 2 * COORD_BITS + 4;
	localparam int CMPW = (CW - 1 > SW_BITS) ? CW - 1 : SW_BITS;
	localparam logic [COORD_BITS-1:0] OX_MAX   = '1;
	localparam logic [COORD_BITS:0]   OY_MAX   = '1;
	localparam logic [COORD_BITS-2:0] PMAG_MAX = '1;

	function automatic logic signed [CW-1:0] sat_row(input logic signed [CW:0] v);
		logic signed [CW-1:0] s;
		if (v[CW] != v[CW-1]) begin
			s = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			s = v[CW-1:0];
		end
		return s;
	endfunction

	function automatic logic on_screen(input logic signed [CW-1:0] c,
			input logic [SW_BITS-1:0] w);
		return !c[CW-1] && (CMPW'(c[CW-2:0]) < CMPW'(w));
	endfunction

	function automatic logic [RW-1:0] abs_r(input logic signed [RW-1:0] v);
		return v[RW-1] ? RW'(-v) : RW'(v);
	endfunction

	logic signed [CW-1:0] orgx_w, offx_w, col, col_n;
	logic signed [CW:0]   orgy_w, offy_w;
	logic signed [RW-1:0] two_p, inc_y, dv_raw, dh_raw, dd_raw;
	logic [RW-1:0]        dv, dh, dd;
	logic                 step_x, step_y, take_x, take_y, last_n;
	logic [COORD_BITS-1:0] p_abs, ox_n;
	logic [COORD_BITS:0]   oy_n;

	assign orgx_w = CW'(origin_x);
	assign offx_w = CW'(offset_x);
	assign col    = flags.opens_right ? orgx_w + offx_w : orgx_w - offx_w;
	assign orgy_w = (CW+1)'(origin_y);
	assign offy_w = (CW+1)'(offset_y);

	// Moving one column costs 2p, moving one row costs 2y+1.
	assign two_p  = RW'({param_mag, 1'b0});
	assign inc_y  = RW'({offset_y, 1'b1});
	assign dv_raw = resid + inc_y;
	assign dh_raw = resid - two_p;
	assign dd_raw = dv_raw - two_p;
	assign dv     = abs_r(dv_raw);
	assign dh     = abs_r(dh_raw);
	assign dd     = abs_r(dd_raw);

	// The vertical step wins a tie with the horizontal one, a plain step wins
	// a tie with the diagonal one.
	always_comb begin
		if (dh < dv) begin
			step_x = 1'b1;
			step_y = dd < dh;
		end else begin
			step_y = 1'b1;
			step_x = dd < dv;
		end
	end

	assign take_x = step_x && (offset_x != OX_MAX);
	assign take_y = step_y && (offset_y != OY_MAX);
	assign ox_n   = take_x ? offset_x + 1'b1 : offset_x;
	assign oy_n   = take_y ? offset_y + 1'b1 : offset_y;
	assign col_n  = !take_x ? col : (flags.opens_right ? col + 1'b1 : col - 1'b1);
	assign last_n = !on_screen(col_n, visible_cols) ||
			((ox_n == OX_MAX) && (oy_n == OY_MAX));

	assign p_abs = focal_param[COORD_BITS-1] ? COORD_BITS'(-focal_param)
			: COORD_BITS'(focal_param);

	always_comb begin
		nxt_flags     = flags;
		nxt_origin_x  = origin_x;
		nxt_origin_y  = origin_y;
		nxt_param_mag = param_mag;
		nxt_offset_x  = offset_x;
		nxt_offset_y  = offset_y;
		nxt_resid     = resid;
		point_x       = '0;
		point_y_upper = '0;
		point_y_lower = '0;
		res_flags     = '0;
		unique case (op)
			OP_START: begin
				nxt_origin_x          = vertex_x;
				nxt_origin_y          = vertex_y;
				nxt_flags.opens_right = !focal_param[COORD_BITS-1] && (focal_param != '0);
				nxt_param_mag         = p_abs[COORD_BITS-1] ? PMAG_MAX : p_abs[COORD_BITS-2:0];
				nxt_offset_x          = '0;
				nxt_offset_y          = '0;
				nxt_resid             = '0;
				nxt_flags.active      = 1'b1;
			end
			OP_ADVANCE: begin
				if (!flags.active) begin
					res_flags.last = 1'b1;
				end else begin
					point_x       = col;
					point_y_upper = sat_row(orgy_w - offy_w);
					point_y_lower = sat_row(orgy_w + offy_w);
					if (!on_screen(col, visible_cols)) begin
						res_flags.last   = 1'b1;
						nxt_flags.active = 1'b0;
					end else begin
						res_flags.point_valid = 1'b1;
						nxt_offset_x = ox_n;
						nxt_offset_y = oy_n;
						nxt_resid    = resid + (take_y ? inc_y : '0) - (take_x ? two_p : '0);
						if (last_n) begin
							res_flags.last   = 1'b1;
							nxt_flags.active = 1'b0;
						end
					end
				end
			end
			default: begin
				res_flags = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

/* tb/tb_parabola_rasterizer.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Parabola rasterizer testbench
// Streams start and advance items into the rasterizer. A behavioral tracer of
// the curve predicts every output point pair, and a checker compares each
// returned item field by field. The stimulus covers several screen widths,
// random idle on both stream sides and a long output stall.
// -----------------------------------------------------------------------------
module tb_parabola_rasterizer;
	import prast_pkg::*;

	localparam int CB = 13;
	localparam longint OFFX_LIMIT = (64'sd1 <<< CB) - 1;
	localparam longint OFFY_LIMIT = (64'sd1 <<< (CB + 1)) - 1;
	localparam longint PMAG_LIMIT = (64'sd1 <<< (CB - 1)) - 1;
	localparam longint ROW_MAX = (64'sd1 <<< (CB + 1)) - 1;
	localparam longint ROW_MIN = -(64'sd1 <<< (CB + 1));

	// One output item as the tracer expects it.
	typedef struct {
		logic signed [CB+1:0] x;
		logic signed [CB+1:0] y_upper;
		logic signed [CB+1:0] y_lower;
		logic                 valid;
		logic                 last;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [SW_BITS-1:0]       cfg_data = '0;

	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// tdata, lowest bit first: vertex_x, vertex_y, focal_param, zero fill.
	logic [39:0]              s_axis_tdata = '0;
	// tuser: opcode.
	logic                     s_axis_tuser = 1'b0;

	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// tdata, lowest bit first: point_x, point_y_upper, point_y_lower, zero fill.
	logic [47:0]              m_axis_tdata;
	// tuser: point_valid.
	logic                     m_axis_tuser;
	logic                     m_axis_tlast;

	parabola_rasterizer #(
		.COORD_BITS(CB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Curve state of the tracer, mirroring what the block keeps.
	longint scr_width = 640;
	longint off_x = 0;
	longint off_y = 0;
	longint org_x = 0;
	longint org_y = 0;
	longint p_mag = 0;
	bit     right_side = 1'b0;
	bit     loaded = 1'b0;

	point_t expected_points[$];
	int     fail_count = 0;

	// Idle percentages of both stream sides, and a long output stall in cycles.
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int sink_hold = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Generous ceiling, far above what a full run with every stall needs.
	initial begin
		#5_000_000;
		$display("[parabola_rasterizer] ERROR");
		$finish;
	end

	// The receiver either holds off for a counted stretch or idles at random.
	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				sink_hold = sink_hold - 1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic logic signed [CB+1:0] clamp_out(longint v);
		if (v > ROW_MAX)
			v = ROW_MAX;
		if (v < ROW_MIN)
			v = ROW_MIN;
		return v[CB+1:0];
	endfunction

	function automatic longint abs_residual(longint x, longint y);
		longint r;
		r = y * y - 2 * p_mag * x;
		return (r < 0) ? -r : r;
	endfunction

	function automatic longint column_at(longint ox);
		return right_side ? org_x + ox : org_x - ox;
	endfunction

	function automatic bit visible(longint c);
		return (c >= 0) && (c < scr_width);
	endfunction

	// Works out the point pair that one accepted item produces and updates the
	// tracer's curve state: a start loads it, an advance moves it by one step.
	function automatic point_t trace_point(opcode_t op, logic signed [CB-1:0] vx,
			logic signed [CB-1:0] vy, logic signed [CB-1:0] p);
		point_t pt;
		longint col, pl, dh, dv, dd;
		bit step_x, step_y;
		pt = '{x: '0, y_upper: '0, y_lower: '0, valid: 1'b0, last: 1'b0};
		if (op == OP_START) begin
			org_x = vx;
			org_y = vy;
			pl = p;
			right_side = (pl > 0);
			if (pl < 0)
				pl = -pl;
			p_mag = (pl > PMAG_LIMIT) ? PMAG_LIMIT : pl;
			off_x = 0;
			off_y = 0;
			loaded = 1'b1;
			return pt;
		end
		// An advance with no curve loaded only reports the end.
		if (!loaded) begin
			pt.last = 1'b1;
			return pt;
		end
		col = column_at(off_x);
		pt.x = clamp_out(col);
		pt.y_upper = clamp_out(org_y - off_y);
		pt.y_lower = clamp_out(org_y + off_y);
		if (!visible(col)) begin
			pt.last = 1'b1;
			loaded = 1'b0;
			return pt;
		end
		pt.valid = 1'b1;
		dd = abs_residual(off_x + 1, off_y + 1);
		dh = abs_residual(off_x + 1, off_y);
		dv = abs_residual(off_x, off_y + 1);
		// Ties go to the vertical step, and to the plain step over the diagonal.
		if (dh < dv) begin
			step_x = 1'b1;
			step_y = (dd < dh);
		end else begin
			step_y = 1'b1;
			step_x = (dd < dv);
		end
		if (step_x && off_x < OFFX_LIMIT)
			off_x++;
		if (step_y && off_y < OFFY_LIMIT)
			off_y++;
		if (!visible(column_at(off_x)) || (off_x == OFFX_LIMIT && off_y == OFFY_LIMIT)) begin
			pt.last = 1'b1;
			loaded = 1'b0;
		end
		return pt;
	endfunction

	// Offers one item, with random idle ahead of it, and records its expected
	// result once the block has accepted it. The valid stays high afterwards
	// so that back-to-back items need no second assignment in one step.
	task automatic send_item(opcode_t op, logic [CB-1:0] vx, logic [CB-1:0] vy,
			logic [CB-1:0] p);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {1'b0, p, vy, vx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_points.push_back(trace_point(op, vx, vy, p));
	endtask

	// The sender goes quiet until every expected result has come back.
	task automatic drain_points();
		s_axis_tvalid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	// Every item yields a result, so an empty queue means the block is idle.
	task automatic set_screen_width(int w);
		drain_points();
		cfg_valid <= 1'b1;
		cfg_data <= w[SW_BITS-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		scr_width = w[SW_BITS-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic advance(int n);
		repeat (n)
			send_item(OP_ADVANCE, '0, '0, '0);
	endtask

	// A start item followed by a run of advances. Most runs stop soon after
	// the curve ends; some keep going into the unloaded state or are cut
	// short by the next start.
	task automatic random_curve(ref int count);
		int w, vx, run;
		logic [CB-1:0] p;
		w = (scr_width > 4096) ? 4096 : int'(scr_width);
		if (w < 1)
			w = 1;
		case ($urandom_range(3))
			0: vx = w - 1 - $urandom_range((w > 8) ? 8 : w - 1);
			1: vx = $urandom_range((w > 8) ? 8 : w - 1);
			2: vx = $urandom_range(w - 1);
			default: vx = int'($urandom_range(8)) - 4 + ($urandom_range(1) ? w : 0);
		endcase
		case ($urandom_range(9))
			0, 1, 2: p = CB'($urandom_range(16) - 8);
			3: p = 13'h1000;
			4: p = 13'h0fff;
			5: p = '0;
			default: p = CB'($urandom());
		endcase
		send_item(OP_START, vx[CB-1:0], CB'($urandom()), p);
		count++;
		run = $urandom_range(1, 30);
		repeat (run) begin
			if (!loaded && $urandom_range(3) != 0)
				break;
			advance(1);
			count++;
		end
	endtask

	// Extremes of every field and each named corner of the curve logic.
	task automatic test_directed();
		// Default width after reset; nothing loaded yet.
		advance(1);
		// p = 0 opens left and only steps horizontally; the next column is -1.
		send_item(OP_START, 13'd0, 13'd0, 13'd0);
		advance(3);
		// Largest p at the right edge: vertical steps first, upper row extreme.
		send_item(OP_START, 13'd639, 13'h0fff, 13'h0fff);
		advance(3);
		// Small p at the right edge: the next column leaves the screen.
		send_item(OP_START, 13'd639, 13'h1000, 13'd1);
		advance(2);
		// Vertex left of the screen, most negative p.
		send_item(OP_START, 13'h1000, 13'd100, 13'h1000);
		advance(1);
		// Vertex beyond the right edge, opening left with saturated magnitude.
		send_item(OP_START, 13'h0fff, 13'd0, 13'h1000);
		advance(1);
		send_item(OP_START, 13'd5, 13'h1fff, 13'h1ffd);
		advance(4);
		// Zero width: no column is ever visible.
		set_screen_width(0);
		send_item(OP_START, 13'd0, 13'd7, 13'd5);
		advance(1);
		set_screen_width(1);
		send_item(OP_START, 13'd0, 13'd3, 13'd2);
		advance(3);
		set_screen_width(8191);
		send_item(OP_START, 13'h0fff, 13'h1555, 13'h0aaa);
		advance(2);
	endtask

	// Mostly well-formed curves with random content, some raw noise items.
	task automatic test_random_phase(int w, int src_pct, int sink_pct, int items);
		int count;
		count = 0;
		set_screen_width(w);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		while (count < items) begin
			if ($urandom_range(9) == 0) begin
				send_item(opcode_t'($urandom_range(1)), CB'($urandom()), CB'($urandom()),
					CB'($urandom()));
				count++;
			end else begin
				random_curve(count);
			end
			// Now and then the sender waits for the block to empty out.
			if ($urandom_range(19) == 0)
				drain_points();
		end
	endtask

	// The receiver holds off long enough for the block to stall its input
	// while the sender keeps offering items.
	task automatic test_output_stall();
		int count;
		count = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		sink_hold = 300;
		while (count < 40)
			random_curve(count);
		drain_points();
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected item tdata %h tuser %b tlast %b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = expected_points.pop_front();
				check_field("point_x", want.x, $signed(m_axis_tdata[14:0]));
				check_field("point_y_upper", want.y_upper, $signed(m_axis_tdata[29:15]));
				check_field("point_y_lower", want.y_lower, $signed(m_axis_tdata[44:30]));
				check_field("point_valid", want.valid, m_axis_tuser);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase($urandom_range(8, 64), 25, 73, 120);
		test_random_phase($urandom_range(1, 16), 73, 25, 120);
		test_random_phase(4096, 0, 0, 120);
		test_output_stall();
		drain_points();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[parabola_rasterizer] OK");
		else
			$display("[parabola_rasterizer] ERROR");
		$finish;
	end

endmodule
